### hw/rtl/phpd_pkg.sv
`timescale 1ns / 1ps

package phpd_pkg;

	// Field widths
	localparam int ADC_W      = 12;
	localparam int POS_W      = 15;
	localparam int TGT_W      = 16;
	localparam int INTEG_W    = 16;
	localparam int ERR_W      = 17;
	localparam int SUM_W      = 18;
	localparam int ACC_W      = 36;
	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 15;
	localparam int DUTY_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Magnitude divider: dividend below 20 * 128, quotient up to 127
	localparam int DIV_W  = 12;
	localparam int QUOT_W = 7;

	// Arithmetic constants
	localparam int OUT_DIV   = 20;
	localparam int POS_MID   = 2047;
	localparam int POS_SHIFT = 2;

	// Register reset values
	localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST = LIM_W'(300);
	localparam logic [DUTY_W-1:0] DEAD_ZONE_RST   = DUTY_W'(5);

	// Item opcodes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_COMMAND = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd4;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop_gain;
		logic signed [GAIN_W-1:0] integ_gain;
		logic signed [GAIN_W-1:0] deriv_gain;
		logic [LIM_W-1:0]         integral_limit;
		logic [DUTY_W-1:0]        dead_zone;
	} cfg_regs_t;

	typedef struct packed {
		logic signed [POS_W-1:0]   position;
		logic signed [TGT_W-1:0]   target;
		logic signed [INTEG_W-1:0] integral_sum;
		logic signed [ERR_W-1:0]   previous_error;
	} pid_state_t;

	typedef struct packed {
		logic [DUTY_W-1:0]         duty;
		logic                      direction;
		logic signed [INTEG_W-1:0] integral_sum;
		logic signed [ERR_W-1:0]   previous_error;
	} pid_result_t;

endpackage

### hw/rtl/phpd_in_if.sv
`timescale 1ns / 1ps

interface phpd_in_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     op;
	logic [phpd_pkg::ADC_W-1:0]               adc_sample;
	logic signed [phpd_pkg::TGT_W-1:0]        destination;

	modport source (output valid, output op, output adc_sample, output destination,
		input ready);
	modport sink (input valid, input op, input adc_sample, input destination,
		output ready);
endinterface

### hw/rtl/phpd_out_if.sv
`timescale 1ns / 1ps

interface phpd_out_if;
	logic                          valid;
	logic                          ready;
	logic                          drive_a;
	logic                          drive_b;
	logic [phpd_pkg::DUTY_W-1:0]   duty_level;
	logic                          reverse_dir;
	logic                          loop_updated;

	modport source (output valid, output drive_a, output drive_b, output duty_level,
		output reverse_dir, output loop_updated, input ready);
	modport sink (input valid, input drive_a, input drive_b, input duty_level,
		input reverse_dir, input loop_updated, output ready);
endinterface

### hw/rtl/phpd_cfg_if.sv
`timescale 1ns / 1ps

interface phpd_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [phpd_pkg::CFG_IDX_W-1:0]      index;
	logic [phpd_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/pid_hbridge_pwm_drive.sv
`timescale 1ns / 1ps

// PID position loop driving an H-bridge by PWM. A command item (op = 1) loads
// position = (adc_sample - 2047) * 4 and the target and gives no result; a tick
// item (op = 0) gives one result with the pin levels for that tick and the
// duty and direction in use, and on the tick where the PWM counter wraps it
// also runs one PID step (loop_updated = 1) whose new duty shows in that
// result. One item is taken per clock cycle unless a tick waits on a stalled
// output: an item is held in the input register, where the whole update
// (three gain multipliers, the wide sum and the divide by 20) settles, and
// its result is registered in the output register, from which it is taken.
// Output stalls back up through ready; the input keeps flowing while the
// output register is free or being drained. Configuration writes are taken
// every cycle and belong to idle periods.
module pid_hbridge_pwm_drive #(
	parameter int PWM_PERIOD = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	phpd_in_if.sink     cmd,
	phpd_out_if.source  drive,
	phpd_cfg_if.sink    cfg
);
	import phpd_pkg::*;

	localparam int CNT_W = $clog2(PWM_PERIOD);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PWM_PERIOD - 1);

	// Configuration registers
	cfg_regs_t regs_q;

	// Loop state
	logic [CNT_W-1:0]  count_q;
	logic [DUTY_W-1:0] duty_q;
	logic              dir_q;
	pid_state_t        st_q;

	// Input register
	logic                     vld_s1;
	logic                     op_s1;
	logic [ADC_W-1:0]         adc_s1;
	logic signed [TGT_W-1:0]  dest_s1;

	// Output register
	logic              out_vld_q;
	logic              drv_a_q;
	logic              drv_b_q;
	logic [DUTY_W-1:0] duty_out_q;
	logic              rev_q;
	logic              upd_q;

	logic              out_free;
	logic              advance;
	logic              tick_go;
	logic              cmd_go;
	logic              wrap;
	logic              pwm_on;
	logic signed [ADC_W:0] adc_off;
	pid_result_t       pid_res;

	phpd_pid_calc #(
		.PWM_PERIOD (PWM_PERIOD)
	) u_pid (
		.regs (regs_q),
		.st   (st_q),
		.res  (pid_res)
	);

	// Handshake
	assign out_free  = !out_vld_q || drive.ready;
	assign advance   = vld_s1 && ((op_s1 == OP_COMMAND) || out_free);
	assign tick_go   = advance && (op_s1 == OP_TICK);
	assign cmd_go    = advance && (op_s1 == OP_COMMAND);
	assign cmd.ready = !vld_s1 || advance;
	assign cfg.ready = 1'b1;

	assign wrap    = count_q == CNT_LAST;
	assign pwm_on  = DUTY_W'(count_q) < duty_q;
	assign adc_off = $signed({1'b0, adc_s1}) - $signed((ADC_W + 1)'(POS_MID));

	// Configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.prop_gain      <= '0;
			regs_q.integ_gain     <= '0;
			regs_q.deriv_gain     <= '0;
			regs_q.integral_limit <= INTEG_LIMIT_RST;
			regs_q.dead_zone      <= DEAD_ZONE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PROP_GAIN:   regs_q.prop_gain      <= $signed(cfg.data);
				REG_INTEG_GAIN:  regs_q.integ_gain     <= $signed(cfg.data);
				REG_DERIV_GAIN:  regs_q.deriv_gain     <= $signed(cfg.data);
				REG_INTEG_LIMIT: regs_q.integral_limit <= cfg.data[LIM_W-1:0];
				REG_DEAD_ZONE:   regs_q.dead_zone      <= cfg.data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1   <= cmd.op;
			adc_s1  <= cmd.adc_sample;
			dest_s1 <= cmd.destination;
		end
	end

	// Loop state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			duty_q  <= '0;
			dir_q   <= 1'b0;
			st_q    <= '0;
		end else begin
			if (cmd_go) begin
				st_q.position <= {adc_off, POS_SHIFT'(0)};
				st_q.target   <= dest_s1;
			end
			if (tick_go) begin
				count_q <= wrap ? '0 : count_q + 1'b1;
				if (wrap) begin
					duty_q              <= pid_res.duty;
					dir_q               <= pid_res.direction;
					st_q.integral_sum   <= pid_res.integral_sum;
					st_q.previous_error <= pid_res.previous_error;
				end
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= tick_go;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (tick_go) begin
			drv_a_q    <= pwm_on && !dir_q;
			drv_b_q    <= pwm_on && dir_q;
			duty_out_q <= wrap ? pid_res.duty : duty_q;
			rev_q      <= wrap ? pid_res.direction : dir_q;
			upd_q      <= wrap;
		end
	end

	assign drive.valid        = out_vld_q;
	assign drive.drive_a      = drv_a_q;
	assign drive.drive_b      = drv_b_q;
	assign drive.duty_level   = duty_out_q;
	assign drive.reverse_dir  = rev_q;
	assign drive.loop_updated = upd_q;

endmodule

### hw/rtl/phpd_pid_calc.sv
`timescale 1ns / 1ps

// One PID update: error, clamped integral, three gain products, exact sum,
// magnitude over 20, cap at the PWM period and dead zone.
module phpd_pid_calc #(
	parameter int PWM_PERIOD = 100
) (
	input  phpd_pkg::cfg_regs_t   regs,
	input  phpd_pkg::pid_state_t  st,
	output phpd_pkg::pid_result_t res
);
	import phpd_pkg::*;

	// Magnitudes at or above this divide to more than the period
	localparam logic [ACC_W-1:0] CAP_LIMIT = ACC_W'(OUT_DIV * (PWM_PERIOD + 1));

	// Reciprocal of 20, rounded up; exact floor for any 12-bit dividend
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((1 << RECIP_SHIFT) / OUT_DIV + 1);

	logic signed [ERR_W-1:0]    err;
	logic signed [SUM_W-1:0]    isum;
	logic signed [SUM_W-1:0]    lim_pos;
	logic signed [SUM_W-1:0]    lim_neg;
	logic                       in_range;
	logic signed [INTEG_W-1:0]  integ_next;
	logic signed [SUM_W-1:0]    derr;
	logic signed [32:0]         prod_p;
	logic signed [33:0]         prod_d;
	logic signed [31:0]         prod_i;
	logic signed [ACC_W-1:0]    acc;
	logic [ACC_W-1:0]           mag;
	logic                       capped;
	logic [DIV_W+RECIP_SHIFT-1:0] quot_prod;
	logic [QUOT_W-1:0]          quot;
	logic [DUTY_W-1:0]          duty_raw;

	// Error and integral window
	assign err      = ERR_W'(st.position) - ERR_W'(st.target);
	assign isum     = SUM_W'(st.integral_sum) + SUM_W'(err);
	assign lim_pos  = $signed(SUM_W'(regs.integral_limit));
	assign lim_neg  = -lim_pos;
	assign in_range = (isum < lim_pos) && (isum > lim_neg);
	assign integ_next = in_range ? isum[INTEG_W-1:0] : st.integral_sum;
	assign derr     = SUM_W'(err) - SUM_W'(st.previous_error);

	// Gain products, summed wide
	assign prod_p = regs.prop_gain * err;
	assign prod_d = regs.deriv_gain * derr;
	assign prod_i = regs.integ_gain * integ_next;
	assign acc    = ACC_W'(prod_p) + ACC_W'(prod_d) + ACC_W'(prod_i);

	// Truncating divide then abs equals floor of magnitude over 20
	assign mag    = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
	assign capped = mag >= CAP_LIMIT;

	// Divide by 20 on the uncapped range by reciprocal multiply
	assign quot_prod = mag[DIV_W-1:0] * RECIP;
	assign quot      = quot_prod[RECIP_SHIFT +: QUOT_W];

	assign duty_raw = capped ? DUTY_W'(PWM_PERIOD) : DUTY_W'(quot);

	// Result
	always_comb begin
		res.duty           = (duty_raw < regs.dead_zone) ? '0 : duty_raw;
		res.direction      = err > 0;
		res.integral_sum   = integ_next;
		res.previous_error = err;
	end

endmodule
